@@ hw/rtl/sbre_pkg.sv @@
// ----------------------------------------------------------------------------
// sbre_pkg
// Shared constants and types of the sprite bounding-box run-length encoder.
// ----------------------------------------------------------------------------
package sbre_pkg;

  localparam int unsigned TileSide = 64;
  localparam int unsigned CoordW   = 6;
  localparam int unsigned AddrW    = 2 * CoordW;
  localparam int unsigned ColW     = CoordW + 1;
  localparam int unsigned IdxW     = 13;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CmdW     = 2;

  localparam logic [PixW-1:0] KeyReset = 8'hFF;

  typedef enum logic [CmdW-1:0] {
    CmdClear = 2'd0,
    CmdWrite = 2'd1,
    CmdRead  = 2'd2
  } cmd_e;

endpackage

@@ hw/rtl/sbre_if.sv @@
// ----------------------------------------------------------------------------
// sbre_if
// Valid/ready channels of the sprite encoder: command in, byte out, key write.
// ----------------------------------------------------------------------------
interface sbre_in_if
  import sbre_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic [PixW-1:0]   pixel_value;

  modport source (output valid, cmd, pixel_x, pixel_y, pixel_value, input ready);
  modport sink   (input valid, cmd, pixel_x, pixel_y, pixel_value, output ready);
endinterface

interface sbre_out_if
  import sbre_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PixW-1:0]   data_byte;
  logic              data_valid;
  logic              is_last;
  logic [IdxW-1:0]   byte_index;
  logic              empty_res;
  logic [CoordW-1:0] box_left;
  logic [ColW-1:0]   box_width;
  logic [CoordW-1:0] box_top;
  logic [ColW-1:0]   box_height;

  modport source (output valid, data_byte, data_valid, is_last, byte_index, empty_res,
                  box_left, box_width, box_top, box_height, input ready);
  modport sink   (input valid, data_byte, data_valid, is_last, byte_index, empty_res,
                  box_left, box_width, box_top, box_height, output ready);
endinterface

interface sbre_cfg_if
  import sbre_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] transparent_key;

  modport source (output valid, transparent_key, input ready);
  modport sink   (input valid, transparent_key, output ready);
endinterface

@@ hw/rtl/sprite_bbox_rle_encoder.sv @@
// ----------------------------------------------------------------------------
// sprite_bbox_rle_encoder
// Holds one 64x64 tile of 8-bit pixels and reads it out run-length encoded.
// ----------------------------------------------------------------------------
// Clear and write items leave the encoder idle; a write lands in the tile RAM
// and, for a pixel other than the key, grows the opaque bounding box. A read
// item passes through the read, scan and emit states; a row terminator or end
// marker skips the scan state, and a run count scans through the single read
// port of the tile RAM one pixel per cycle. One item is in work at a time; a
// finished byte waits in the output register while the next item is taken.
// Key writes are taken in any cycle.
module sprite_bbox_rle_encoder
  import sbre_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  sbre_in_if.sink      in_i,
  sbre_cfg_if.sink     cfg_i,
  sbre_out_if.source   out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  localparam logic [2:0] PhStart  = 3'd0;
  localparam logic [2:0] PhTcount = 3'd1;
  localparam logic [2:0] PhOcount = 3'd2;
  localparam logic [2:0] PhPix    = 3'd3;
  localparam logic [2:0] PhTerm   = 3'd4;
  localparam logic [2:0] PhDone   = 3'd5;

  localparam logic [ColW-1:0] ColEnd = ColW'(TileSide);

  logic [PixW-1:0] tile_mem [TileSide*TileSide];
  logic [PixW-1:0] rdata_q;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;
  logic            wr_en;

  logic [1:0]        state_q, state_d;
  logic [2:0]        phase_q, phase_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [ColW-1:0]   run_q, run_d;
  logic [ColW-1:0]   n_q, n_d;
  logic [IdxW-1:0]   bytes_q, bytes_d;
  logic [PixW-1:0]   key_q, key_d;
  logic [ColW-1:0]   min_col_q, min_col_d, min_row_q, min_row_d;
  logic [CoordW-1:0] max_col_q, max_col_d, max_row_q, max_row_d;

  logic            res_load;
  logic [PixW-1:0] res_byte_q, res_byte_d;
  logic            res_valid_q, res_valid_d;
  logic            res_last_q, res_last_d;
  logic [IdxW-1:0] res_idx_q, res_idx_d;

  logic            out_valid_q, out_valid_d;
  logic            out_load;

  logic            empty;
  logic            in_acc;
  logic            cfg_acc;
  logic [ColW-1:0] cur_col, nxt_col, cnt, pix_col, pix_run;
  logic            match, pix_write_opaque;

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid;

  assign empty = (min_row_q >= ColEnd) || (min_col_q > {1'b0, max_col_q})
              || (min_row_q > {1'b0, max_row_q});

  assign cur_col = col_q + n_q;
  assign nxt_col = cur_col + ColW'(1);
  assign match   = (phase_q == PhTcount) == (rdata_q == key_q);
  assign pix_col = col_q + ColW'(1);
  assign pix_run = (run_q == '0) ? '0 : run_q - ColW'(1);
  assign pix_write_opaque = (in_i.pixel_value != key_q);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    row_d       = row_q;
    col_d       = col_q;
    run_d       = run_q;
    n_d         = n_q;
    bytes_d     = bytes_q;
    key_d       = key_q;
    min_col_d   = min_col_q;
    max_col_d   = max_col_q;
    min_row_d   = min_row_q;
    max_row_d   = max_row_q;
    res_load    = 1'b0;
    res_byte_d  = '0;
    res_valid_d = 1'b1;
    res_last_d  = 1'b0;
    res_idx_d   = bytes_q;
    rd_en       = 1'b0;
    rd_addr     = {row_q, col_q[CoordW-1:0]};
    wr_en       = 1'b0;
    out_load    = 1'b0;
    cnt         = n_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (in_i.cmd)
            CmdClear: begin
              min_col_d = ColEnd;
              min_row_d = ColEnd;
              max_col_d = '0;
              max_row_d = '0;
              phase_d   = PhStart;
              bytes_d   = '0;
              run_d     = '0;
              col_d     = '0;
              row_d     = '0;
            end
            CmdWrite: begin
              wr_en = 1'b1;
              if (pix_write_opaque) begin
                if ({1'b0, in_i.pixel_x} < min_col_q) min_col_d = {1'b0, in_i.pixel_x};
                if (in_i.pixel_x > max_col_q) max_col_d = in_i.pixel_x;
                if ({1'b0, in_i.pixel_y} < min_row_q) min_row_d = {1'b0, in_i.pixel_y};
                if (in_i.pixel_y > max_row_q) max_row_d = in_i.pixel_y;
              end
              phase_d = PhStart;
              bytes_d = '0;
              run_d   = '0;
              col_d   = '0;
              row_d   = '0;
            end
            CmdRead: begin
              state_d = StRead;
              if (phase_q == PhStart) begin
                if (empty) begin
                  phase_d = PhDone;
                end else begin
                  phase_d = PhTcount;
                  row_d   = min_row_q[CoordW-1:0];
                  col_d   = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end

      StRead: begin
        if (phase_q == PhDone) begin
          res_load    = 1'b1;
          res_valid_d = 1'b0;
          res_last_d  = 1'b1;
          state_d     = StEmit;
        end else if (phase_q == PhTerm) begin
          res_load = 1'b1;
          bytes_d  = bytes_q + IdxW'(1);
          state_d  = StEmit;
          if (row_q >= max_row_q) begin
            phase_d    = PhDone;
            res_last_d = 1'b1;
          end else begin
            row_d   = row_q + CoordW'(1);
            col_d   = '0;
            phase_d = PhTcount;
          end
        end else begin
          rd_en   = 1'b1;
          n_d     = '0;
          state_d = StScan;
        end
      end

      StScan: begin
        if (phase_q == PhPix) begin
          res_load   = 1'b1;
          res_byte_d = rdata_q;
          bytes_d    = bytes_q + IdxW'(1);
          col_d      = pix_col;
          run_d      = pix_run;
          state_d    = StEmit;
          if (pix_run == '0 || pix_col >= ColEnd) begin
            phase_d = (pix_col < ColEnd) ? PhTcount : PhTerm;
          end
        end else if (match && nxt_col < ColEnd) begin
          n_d     = n_q + ColW'(1);
          rd_en   = 1'b1;
          rd_addr = {row_q, nxt_col[CoordW-1:0]};
        end else begin
          cnt        = match ? n_q + ColW'(1) : n_q;
          res_load   = 1'b1;
          res_byte_d = PixW'(cnt);
          bytes_d    = bytes_q + IdxW'(1);
          state_d    = StEmit;
          if (phase_q == PhTcount) begin
            col_d   = col_q + cnt;
            phase_d = (col_q + cnt < ColEnd) ? PhOcount : PhTerm;
          end else begin
            run_d   = cnt;
            phase_d = (cnt != '0) ? PhPix : PhTcount;
          end
        end
      end

      StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase

    if (cfg_acc) begin
      key_d   = cfg_i.transparent_key;
      phase_d = PhStart;
      bytes_d = '0;
      run_d   = '0;
      col_d   = '0;
      row_d   = '0;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tile_mem[{in_i.pixel_y, in_i.pixel_x}] <= in_i.pixel_value;
    end
    if (rd_en) begin
      rdata_q <= tile_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhStart;
      row_q       <= '0;
      col_q       <= '0;
      run_q       <= '0;
      n_q         <= '0;
      bytes_q     <= '0;
      key_q       <= KeyReset;
      min_col_q   <= ColEnd;
      min_row_q   <= ColEnd;
      max_col_q   <= '0;
      max_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      row_q       <= row_d;
      col_q       <= col_d;
      run_q       <= run_d;
      n_q         <= n_d;
      bytes_q     <= bytes_d;
      key_q       <= key_d;
      min_col_q   <= min_col_d;
      min_row_q   <= min_row_d;
      max_col_q   <= max_col_d;
      max_row_q   <= max_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_byte_q  <= res_byte_d;
      res_valid_q <= res_valid_d;
      res_last_q  <= res_last_d;
      res_idx_q   <= res_idx_d;
    end
    if (out_load) begin
      out_o.data_byte  <= res_byte_q;
      out_o.data_valid <= res_valid_q;
      out_o.is_last    <= res_last_q;
      out_o.byte_index <= res_idx_q;
      out_o.empty_res  <= empty;
      out_o.box_left   <= empty ? '0 : min_col_q[CoordW-1:0];
      out_o.box_width  <= empty ? '0 : {1'b0, max_col_q} - min_col_q + ColW'(1);
      out_o.box_top    <= empty ? '0 : min_row_q[CoordW-1:0];
      out_o.box_height <= empty ? '0 : {1'b0, max_row_q} - min_row_q + ColW'(1);
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

@@ tb/sprite_bbox_rle_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// sprite_bbox_rle_encoder_tb
// Self-checking bench for the sprite run-length encoder. Directed tests cover
// the empty tile, the box corners, key overwrite, readout restart by clear,
// write and key change, and a long output stall. Random tiles follow under
// four idle/stall profiles and several transparent keys. Every read result is
// compared field by field with a bit-accurate encoder model in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sprite_bbox_rle_encoder_tb;
  import sbre_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 80;
  localparam int RandomItems = 240;

  typedef struct packed {
    logic [PixW-1:0]   data_byte;
    logic              data_valid;
    logic              is_last;
    logic [IdxW-1:0]   byte_index;
    logic              empty_res;
    logic [CoordW-1:0] box_left;
    logic [ColW-1:0]   box_width;
    logic [CoordW-1:0] box_top;
    logic [ColW-1:0]   box_height;
  } enc_byte_t;

  typedef enum int {
    ScanStart,
    ScanTcount,
    ScanOcount,
    ScanPixel,
    ScanTerm,
    ScanDone
  } scan_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbre_in_if  in_if ();
  sbre_cfg_if cfg_if ();
  sbre_out_if out_if ();

  sprite_bbox_rle_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [PixW-1:0] tile_px [TileSide*TileSide];
  logic [TileSide-1:0] row_written [TileSide];
  logic [PixW-1:0] key_model;
  int col_lo, col_hi, row_lo, row_hi;
  int scan_row, scan_col, opaque_left, byte_count;
  scan_phase_e scan_phase;

  enc_byte_t expected_bytes [$];
  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  function automatic void clear_box();
    col_lo = TileSide;
    row_lo = TileSide;
    col_hi = 0;
    row_hi = 0;
  endfunction

  function automatic void restart_scan();
    scan_phase  = ScanStart;
    scan_row    = 0;
    scan_col    = 0;
    opaque_left = 0;
    byte_count  = 0;
  endfunction

  function automatic bit box_rows_ready();
    if (row_lo > row_hi || col_lo > col_hi) return 1'b1;
    for (int r = row_lo; r <= row_hi; r++) begin
      if (row_written[r] != '1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit predict_encoder(input logic [CmdW-1:0] cmd, input int x, input int y,
                                         input int v, output enc_byte_t res);
    bit is_empty;
    int n;
    res = '0;
    n = 0;
    is_empty = (row_lo >= TileSide) || (col_lo > col_hi) || (row_lo > row_hi);
    if (cmd == CmdClear) begin
      clear_box();
      restart_scan();
      return 1'b0;
    end
    if (cmd == CmdWrite) begin
      tile_px[y * TileSide + x] = PixW'(v);
      row_written[y][x] = 1'b1;
      if (PixW'(v) != key_model) begin
        if (x < col_lo) col_lo = x;
        if (x > col_hi) col_hi = x;
        if (y < row_lo) row_lo = y;
        if (y > row_hi) row_hi = y;
      end
      restart_scan();
      return 1'b0;
    end
    if (cmd != CmdRead) return 1'b0;

    if (scan_phase == ScanStart) begin
      if (is_empty) begin
        scan_phase = ScanDone;
      end else begin
        scan_row   = row_lo;
        scan_col   = 0;
        scan_phase = ScanTcount;
      end
    end
    res.byte_index = IdxW'(byte_count);
    case (scan_phase)
      ScanTcount: begin
        while (scan_col < TileSide && tile_px[scan_row * TileSide + scan_col] == key_model) begin
          n++;
          scan_col++;
        end
        res.data_byte  = PixW'(n);
        res.data_valid = 1'b1;
        scan_phase = (scan_col < TileSide) ? ScanOcount : ScanTerm;
      end
      ScanOcount: begin
        while (scan_col + n < TileSide &&
               tile_px[scan_row * TileSide + scan_col + n] != key_model) n++;
        res.data_byte  = PixW'(n);
        res.data_valid = 1'b1;
        opaque_left = n;
        scan_phase = (n > 0) ? ScanPixel : ScanTcount;
      end
      ScanPixel: begin
        res.data_byte  = tile_px[scan_row * TileSide + scan_col];
        res.data_valid = 1'b1;
        scan_col++;
        if (opaque_left > 0) opaque_left--;
        if (opaque_left == 0 || scan_col >= TileSide) begin
          scan_phase = (scan_col < TileSide) ? ScanTcount : ScanTerm;
        end
      end
      ScanTerm: begin
        res.data_valid = 1'b1;
        if (scan_row >= row_hi) begin
          scan_phase  = ScanDone;
          res.is_last = 1'b1;
        end else begin
          scan_row++;
          scan_col   = 0;
          scan_phase = ScanTcount;
        end
      end
      default: begin
        scan_phase  = ScanDone;
        res.is_last = 1'b1;
      end
    endcase
    if (res.data_valid) byte_count = (byte_count + 1) % (1 << IdxW);
    res.empty_res = is_empty;
    if (!is_empty) begin
      res.box_left   = CoordW'(col_lo);
      res.box_width  = ColW'(col_hi - col_lo + 1);
      res.box_top    = CoordW'(row_lo);
      res.box_height = ColW'(row_hi - row_lo + 1);
    end
    return 1'b1;
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input int x, input int y, input int v);
    int gap;
    enc_byte_t res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.pixel_x     <= CoordW'(x);
    in_if.pixel_y     <= CoordW'(y);
    in_if.pixel_value <= PixW'(v);
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (predict_encoder(cmd, x, y, v, res)) expected_bytes.push_back(res);
    items_sent++;
  endtask

  task automatic send_op(input logic [CmdW-1:0] cmd);
    send_item(cmd, $urandom_range(63), $urandom_range(63), $urandom_range(255));
  endtask

  task automatic read_to_end(input int extra);
    while (scan_phase != ScanDone) send_op(CmdRead);
    repeat (extra) send_op(CmdRead);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_key(input logic [PixW-1:0] k);
    wait_drained();
    cfg_if.valid           <= 1'b1;
    cfg_if.transparent_key <= k;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    key_model = k;
    restart_scan();
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  task automatic check_result();
    enc_byte_t exp_b;
    if (expected_bytes.size() == 0) begin
      error_count++;
      $error("unexpected result: data_byte %0d, byte_index %0d",
             out_if.data_byte, out_if.byte_index);
    end else begin
      exp_b = expected_bytes.pop_front();
      check_field("data_byte", exp_b.data_byte, out_if.data_byte);
      check_field("data_valid", exp_b.data_valid, out_if.data_valid);
      check_field("is_last", exp_b.is_last, out_if.is_last);
      check_field("byte_index", exp_b.byte_index, out_if.byte_index);
      check_field("empty_res", exp_b.empty_res, out_if.empty_res);
      check_field("box_left", exp_b.box_left, out_if.box_left);
      check_field("box_width", exp_b.box_width, out_if.box_width);
      check_field("box_top", exp_b.box_top, out_if.box_top);
      check_field("box_height", exp_b.box_height, out_if.box_height);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_result();
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic test_empty_tile();
    send_op(CmdRead);
    send_op(CmdUnused);
    send_op(CmdRead);
  endtask

  // Rows 0 and 63 start fully transparent; rows 1 to 5 and 60 to 62 get a mix.
  task automatic test_tile_preload();
    int sel;
    for (int r = 0; r < TileSide; r++) begin
      if (r <= 5 || r >= 60) begin
        for (int c = 0; c < TileSide; c++) begin
          sel = $urandom_range(99);
          if (r == 0 || r == 63 || sel < 70) send_item(CmdWrite, c, r, KeyReset);
          else if (sel < 85) send_item(CmdWrite, c, r, 0);
          else send_item(CmdWrite, c, r, $urandom_range(255));
        end
      end
    end
  endtask

  task automatic test_box_extremes();
    send_op(CmdClear);
    send_item(CmdWrite, 0, 63, 8'h00);
    send_item(CmdWrite, 63, 63, 8'hFE);
    send_item(CmdWrite, 5, 63, KeyReset);
    read_to_end(1);
    send_item(CmdWrite, 0, 63, KeyReset);
    read_to_end(1);
    send_op(CmdClear);
    send_item(CmdWrite, 31, 0, 8'h80);
    repeat (2) send_op(CmdRead);
    send_op(CmdClear);
    send_op(CmdRead);
  endtask

  task automatic test_key_change();
    set_key(8'h00);
    send_op(CmdClear);
    send_item(CmdWrite, 0, 0, 8'h00);
    send_op(CmdRead);
    send_item(CmdWrite, 63, 0, 8'h01);
    repeat (3) send_op(CmdRead);
    set_key(KeyReset);
    read_to_end(0);
  endtask

  task automatic test_backpressure();
    send_item(CmdWrite, 31, 0, 8'h80);
    hold_off_cycles = 400;
    repeat (8) send_op(CmdRead);
  endtask

  task automatic run_tile();
    int sel, top, h, k;
    bit all_key, broke;
    sel = $urandom_range(99);
    if (sel < 70) begin
      top = $urandom_range(2);
      h   = $urandom_range(1, 4);
    end else if (sel < 97) begin
      top = $urandom_range(60, 63);
      h   = $urandom_range(1, 64 - top);
    end else begin
      top = $urandom_range(6, 59);
      h   = 1;
    end
    all_key = ($urandom_range(9) == 0);
    send_op(CmdClear);
    repeat ($urandom_range(1, 12)) begin
      k = $urandom_range(99);
      if (k < 8) begin
        send_op(CmdUnused);
      end else if (k < 14) begin
        send_item(CmdWrite, $urandom_range(63), $urandom_range(63), int'(key_model));
      end else if (k < 22 && box_rows_ready()) begin
        send_op(CmdRead);
      end else begin
        send_item(CmdWrite, $urandom_range(63), top + $urandom_range(h - 1),
                  (all_key || $urandom_range(1)) ? int'(key_model) : $urandom_range(255));
      end
    end
    // never let a read scan a pixel that was not written
    if (row_lo <= row_hi && col_lo <= col_hi) begin
      for (int r = row_lo; r <= row_hi; r++) begin
        for (int c = 0; c < TileSide; c++) begin
          if (!row_written[r][c]) begin
            send_item(CmdWrite, c, r,
                      ($urandom_range(99) < 85) ? int'(key_model) : $urandom_range(255));
          end
        end
      end
    end
    broke = 1'b0;
    while (scan_phase != ScanDone) begin
      if (!broke && row_lo <= row_hi && $urandom_range(99) < 4) begin
        broke = 1'b1;
        send_item(CmdWrite, $urandom_range(63), row_lo + $urandom_range(row_hi - row_lo),
                  $urandom_range(255));
      end else begin
        send_op(CmdRead);
      end
    end
    repeat ($urandom_range(2)) send_op(CmdRead);
  endtask

  task automatic test_random_tiles();
    int start;
    logic [PixW-1:0] k;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;  k = KeyReset;
        end
        1: begin
          send_idle_pct = 88; recv_stall_pct = 0;  k = PixW'($urandom_range(1, 254));
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 88; k = 8'h00;
        end
        default: begin
          send_idle_pct = 26; recv_stall_pct = 26; k = KeyReset;
        end
      endcase
      set_key(k);
      start = items_sent;
      while (items_sent - start < RandomItems / 4) run_tile();
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.cmd              = CmdClear;
    in_if.pixel_x          = '0;
    in_if.pixel_y          = '0;
    in_if.pixel_value      = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.transparent_key = KeyReset;
    key_model              = KeyReset;
    foreach (row_written[r]) row_written[r] = '0;
    clear_box();
    restart_scan();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_tile();
    test_tile_preload();
    test_box_extremes();
    test_key_change();
    test_backpressure();
    test_random_tiles();

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
